FILE: rtl/utf8_stream_decoder_unit_defines.svh
// Assertion helpers shared by the decoder modules.
`ifndef UTF8_STREAM_DECODER_UNIT_DEFINES_SVH
`define UTF8_STREAM_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define U8SD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define U8SD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/u8sd_pkg.sv
`timescale 1ns / 1ps
package u8sd_pkg;

  localparam int unsigned U8SD_BYTE_W     = 8;
  localparam int unsigned U8SD_CP_W       = 21;
  localparam int unsigned U8SD_CNT_W      = 3;
  localparam int unsigned U8SD_QUEUE_DEPTH = 4;

  localparam logic [U8SD_CP_W-1:0] U8SD_REPL_CHAR  = 21'h00FFFD;
  localparam logic [U8SD_CP_W-1:0] U8SD_MAX_SCALAR = 21'h10FFFF;
  localparam logic [U8SD_CP_W-1:0] U8SD_SURR_LO    = 21'h00D800;
  localparam logic [U8SD_CP_W-1:0] U8SD_SURR_HI    = 21'h00DFFF;
  localparam logic [U8SD_CP_W-1:0] U8SD_MIN_LEN1   = 21'h000080;
  localparam logic [U8SD_CP_W-1:0] U8SD_MIN_LEN2   = 21'h000800;
  localparam logic [U8SD_CP_W-1:0] U8SD_MIN_LEN3   = 21'h010000;

  // One accepted byte's worth of results: cnt results, all but the last
  // are replacements; the last carries cp and rep.
  typedef struct packed {
    logic [U8SD_CNT_W-1:0] cnt;
    logic [U8SD_CP_W-1:0]  cp;
    logic                  rep;
  } u8sd_desc_t;

endpackage

FILE: rtl/u8sd_front.sv
`timescale 1ns / 1ps
`include "utf8_stream_decoder_unit_defines.svh"
module u8sd_front
  import u8sd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic [U8SD_BYTE_W-1:0] text_byte,
  output logic                   desc_valid,
  output u8sd_desc_t             desc
);

  logic [1:0]           len_r, len_nxt;
  logic [1:0]           seen_r, seen_nxt;
  logic [U8SD_CP_W-1:0] part_r, part_nxt;

  logic [U8SD_CP_W-1:0]  acc;
  logic [1:0]            seen_inc;
  logic [U8SD_CP_W-1:0]  min_val;
  logic                  value_ok;
  logic                  is_cont;
  logic [U8SD_CNT_W-1:0] pend;
  logic [U8SD_CNT_W-1:0] tail;

  always_comb begin
    acc      = {part_r[U8SD_CP_W-7:0], text_byte[5:0]};
    seen_inc = seen_r + 2'd1;
    is_cont  = (text_byte[7:6] == 2'b10);
    case (len_r)
      2'd1:    min_val = U8SD_MIN_LEN1;
      2'd2:    min_val = U8SD_MIN_LEN2;
      default: min_val = U8SD_MIN_LEN3;
    endcase
    value_ok = (acc >= min_val) && (acc <= U8SD_MAX_SCALAR) &&
               !((acc >= U8SD_SURR_LO) && (acc <= U8SD_SURR_HI));

    len_nxt  = len_r;
    seen_nxt = seen_r;
    part_nxt = part_r;
    pend     = '0;
    tail     = '0;
    desc.cnt = '0;
    desc.cp  = U8SD_REPL_CHAR;
    desc.rep = 1'b1;

    if ((len_r != 2'd0) && is_cont) begin
      // absorb the continuation; finish the sequence when it is complete
      part_nxt = acc;
      seen_nxt = seen_inc;
      if (seen_inc >= len_r) begin
        len_nxt  = 2'd0;
        seen_nxt = 2'd0;
        part_nxt = '0;
        if (value_ok) begin
          desc.cnt = U8SD_CNT_W'(1);
          desc.cp  = acc;
          desc.rep = 1'b0;
        end else begin
          desc.cnt = U8SD_CNT_W'(len_r) + U8SD_CNT_W'(1);
        end
      end
    end else begin
      // flush the open sequence, then treat the byte as a new lead
      if (len_r != 2'd0) begin
        pend = U8SD_CNT_W'(seen_r) + U8SD_CNT_W'(1);
      end
      len_nxt  = 2'd0;
      seen_nxt = 2'd0;
      part_nxt = '0;
      if (text_byte == '0) begin
        tail = '0;
      end else if (text_byte[7] == 1'b0) begin
        tail     = U8SD_CNT_W'(1);
        desc.cp  = U8SD_CP_W'(text_byte);
        desc.rep = 1'b0;
      end else if (text_byte[7:5] == 3'b110) begin
        len_nxt  = 2'd1;
        part_nxt = U8SD_CP_W'(text_byte[4:0]);
      end else if (text_byte[7:4] == 4'b1110) begin
        len_nxt  = 2'd2;
        part_nxt = U8SD_CP_W'(text_byte[3:0]);
      end else if (text_byte[7:3] == 5'b11110) begin
        len_nxt  = 2'd3;
        part_nxt = U8SD_CP_W'(text_byte[2:0]);
      end else begin
        tail = U8SD_CNT_W'(1);
      end
      desc.cnt = pend + tail;
    end
  end

  assign desc_valid = accept && (desc.cnt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= 2'd0;
      seen_r <= 2'd0;
      part_r <= '0;
    end else if (accept) begin
      len_r  <= len_nxt;
      seen_r <= seen_nxt;
      part_r <= part_nxt;
    end
  end

  `U8SD_ASSERT_NOW(a_seen_below_len, len_r != 2'd0, seen_r < len_r, "continuation count overran")
  `U8SD_ASSERT_NOW(a_closed_is_clear, len_r == 2'd0, (seen_r == 2'd0) && (part_r == '0), "closed sequence holds stale state")
  `U8SD_ASSERT_NOW(a_desc_bounded, desc_valid, desc.cnt <= U8SD_CNT_W'(4), "more than four results for one byte")

endmodule

FILE: rtl/u8sd_queue.sv
`timescale 1ns / 1ps
module u8sd_queue
  import u8sd_pkg::*;
#(
  parameter int unsigned DEPTH = U8SD_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  u8sd_desc_t wr_data,
  output logic       full,
  input  logic       rd_en,
  output u8sd_desc_t rd_data,
  output logic       empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  u8sd_desc_t         mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_wr, do_rd;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

FILE: rtl/u8sd_back.sv
`timescale 1ns / 1ps
`include "utf8_stream_decoder_unit_defines.svh"
module u8sd_back
  import u8sd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  u8sd_desc_t           head,
  input  logic                 q_empty,
  output logic                 q_rd_en,
  input  logic                 pop,
  output logic [U8SD_CP_W-1:0] code_point,
  output logic                 replaced,
  output logic                 last_of_run
);

  logic [1:0] idx_r, idx_nxt;
  logic       is_last;
  logic       xfer;

  assign is_last     = ((U8SD_CNT_W'(idx_r) + U8SD_CNT_W'(1)) == head.cnt);
  assign xfer        = pop && !q_empty;
  assign q_rd_en     = xfer && is_last;
  assign code_point  = is_last ? head.cp  : U8SD_REPL_CHAR;
  assign replaced    = is_last ? head.rep : 1'b1;
  assign last_of_run = is_last;

  always_comb begin
    idx_nxt = idx_r;
    if (xfer) begin
      idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  `U8SD_ASSERT_NOW(a_idx_in_run, !q_empty, U8SD_CNT_W'(idx_r) < head.cnt, "result index past its run")
  `U8SD_ASSERT_NOW(a_idx_idle, q_empty, idx_r == 2'd0, "run index left open on empty queue")
  `U8SD_ASSERT_NEXT(a_idx_wrap, xfer && is_last, idx_r == 2'd0, "run index did not restart")

endmodule

FILE: rtl/utf8_stream_decoder_unit.sv
`timescale 1ns / 1ps
// UTF-8 stream decoder.
// Input side is a queue: present one text byte on in_text_byte with push;
// the byte transfers on a clock edge where push is high and full is low.
// A zero byte terminates the text: it flushes replacements still owed for an
// open sequence and yields no code point of its own.
// Result side is a queue too: while empty is low the oldest result sits on
// out_code_point / out_replaced / out_last_of_run, and it transfers on an
// edge where pop is high. out_last_of_run marks the final result of a byte.
// On an empty queue, a byte's first result is visible the cycle after its transfer.
// Throughput: one byte per cycle while each byte yields at most one result;
// an error run emits up to four U+FFFD results, one per cycle on the result
// side while pop is high, while the descriptor queue (QUEUE_DEPTH entries)
// keeps absorbing input. full rises only when that queue is full, i.e. when
// the receiver stalls or replacement runs outpace the result side.
// Reset (rst_n low, synchronous) closes any open sequence and drops every
// queued result. Stalling pop holds the current result steady.
module utf8_stream_decoder_unit
  import u8sd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = U8SD_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  logic [U8SD_BYTE_W-1:0] in_text_byte,
  output logic                   empty,
  input  logic                   pop,
  output logic [U8SD_CP_W-1:0]   out_code_point,
  output logic                   out_replaced,
  output logic                   out_last_of_run
);

  logic       accept;
  logic       desc_valid;
  u8sd_desc_t desc;
  u8sd_desc_t head;
  logic       q_rd_en;

  // Transfer a byte only when a descriptor slot is free.
  assign accept = push && !full;

  // Front: track the open sequence and classify each byte into a run.
  u8sd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .text_byte  (in_text_byte),
    .desc_valid (desc_valid),
    .desc       (desc)
  );

  // Queue of runs between classification and emission.
  u8sd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (desc_valid),
    .wr_data (desc),
    .full    (full),
    .rd_en   (q_rd_en),
    .rd_data (head),
    .empty   (empty)
  );

  // Back: expand the head run into individual results.
  u8sd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .q_empty     (empty),
    .q_rd_en     (q_rd_en),
    .pop         (pop),
    .code_point  (out_code_point),
    .replaced    (out_replaced),
    .last_of_run (out_last_of_run)
  );

endmodule
